>>> hdl/sctm_pkg.sv
// Shared types and constants of the scan cycle timing monitor.
package sctm_pkg;
  localparam int unsigned TsW = 48;
  localparam int unsigned StatW = 32;
  localparam int unsigned QueueDepthDef = 2;
  localparam logic [31:0] PeriodResetNs = 32'd20000000;
  localparam logic CmdStart = 1'b0;
  localparam logic CmdEnd = 1'b1;
  // Nanoseconds to microseconds: multiply by ceil(2^38 / 1000), keep bits 60..38.
  // This is exact for every 32-bit period.
  localparam logic [28:0] UsRecip = 29'd274877907;
  localparam int unsigned UsRecipShift = 38;

  typedef struct packed {
    logic cmd;
    logic [TsW-1:0] ts;
  } evt_t;

  typedef struct packed {
    logic stats_valid;
    logic [StatW-1:0] n_start;
    logic [StatW-1:0] st_min;
    logic [StatW-1:0] st_max;
    logic [StatW-1:0] st_mean;
    logic [StatW-1:0] ct_min;
    logic [StatW-1:0] ct_max;
    logic [StatW-1:0] ct_mean;
    logic signed [StatW-1:0] latency_min;
    logic signed [StatW-1:0] latency_max;
    logic signed [StatW-1:0] latency_avg;
    logic [StatW-1:0] overrun_count;
  } stats_t;
endpackage

>>> hdl/scan_cycle_timing_monitor.sv
// Top level of the scan cycle timing monitor.
//   channel | ports                          | handshake
//   input   | in_cmd, in_timestamp_us        | push / full
//   result  | out_* statistics fields        | empty / pop
//   config  | cfg_we, cfg_period_ns          | write strobe
// A start after the first runs two divisions of the sequential divider for the
// running means, at one quotient bit per cycle, and an end runs one; a first start
// or an ignored end reaches the result without the divider.
// Reset is synchronous; the result word holds until popped and the engine
// waits for it before taking the next word from the input queue.
module scan_cycle_timing_monitor #(
  parameter int unsigned QueueDepth = sctm_pkg::QueueDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  logic in_cmd,
  input  logic [47:0] in_timestamp_us,
  output logic empty,
  input  logic pop,
  output logic out_stats_valid,
  output logic [31:0] out_scan_count,
  output logic [31:0] out_scan_time_min,
  output logic [31:0] out_scan_time_max,
  output logic [31:0] out_scan_time_avg,
  output logic [31:0] out_cycle_time_min,
  output logic [31:0] out_cycle_time_max,
  output logic [31:0] out_cycle_time_avg,
  output logic signed [31:0] out_latency_min,
  output logic signed [31:0] out_latency_max,
  output logic signed [31:0] out_latency_avg,
  output logic [31:0] out_overrun_count,
  input  logic cfg_we,
  input  logic [31:0] cfg_period_ns
);
  import sctm_pkg::*;

  logic [31:0] period_r;
  evt_t in_evt, q_evt;
  logic q_valid, q_take, res_valid;
  stats_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PeriodResetNs;
    end else if (cfg_we) begin
      period_r <= cfg_period_ns;
    end
  end

  assign in_evt.cmd = in_cmd;
  assign in_evt.ts = in_timestamp_us;

  sctm_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .push_evt(in_evt),
    .q_valid(q_valid), .q_take(q_take), .q_evt(q_evt)
  );

  sctm_back u_back (
    .clk(clk), .rst_n(rst_n), .period_ns(period_r), .q_valid(q_valid),
    .q_take(q_take), .q_evt(q_evt), .res_valid(res_valid), .res_pop(pop), .res(res)
  );

  assign empty = !res_valid;
  assign out_stats_valid = res.stats_valid;
  assign out_scan_count = res.n_start;
  assign out_scan_time_min = res.st_min;
  assign out_scan_time_max = res.st_max;
  assign out_scan_time_avg = res.st_mean;
  assign out_cycle_time_min = res.ct_min;
  assign out_cycle_time_max = res.ct_max;
  assign out_cycle_time_avg = res.ct_mean;
  assign out_latency_min = res.latency_min;
  assign out_latency_max = res.latency_max;
  assign out_latency_avg = res.latency_avg;
  assign out_overrun_count = res.overrun_count;
endmodule

>>> hdl/sctm_front.sv
// Front end: input word queue that decouples acceptance from the statistics engine.
module sctm_front #(
  parameter int unsigned Depth = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  sctm_pkg::evt_t push_evt,
  output logic q_valid,
  input  logic q_take,
  output sctm_pkg::evt_t q_evt
);
  import sctm_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  evt_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic do_push, do_pop;

  assign full = (cnt_r == (AW+1)'(Depth));
  assign q_valid = (cnt_r != '0);
  assign q_evt = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

>>> hdl/sctm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sctm_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [33:0] dividend,
  input  logic [31:0] divisor,
  output logic busy,
  output logic signed [33:0] quotient
);
  logic [33:0] rem_r, quo_r;
  logic [31:0] dvs_r;
  logic neg_r;
  logic [5:0] cnt_r;
  logic [34:0] trial;

  assign busy = (cnt_r != '0);
  assign trial = {rem_r, quo_r[33]} - {3'b0, dvs_r};
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 6'd34;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[33] ? 34'(-dividend) : dividend;
      dvs_r <= divisor;
      neg_r <= dividend[33];
    end else if (busy) begin
      if (!trial[34]) begin
        rem_r <= trial[33:0];
        quo_r <= {quo_r[32:0], 1'b1};
      end else begin
        rem_r <= {rem_r[32:0], quo_r[33]};
        quo_r <= {quo_r[32:0], 1'b0};
      end
    end
  end
endmodule

>>> hdl/sctm_back.sv
// Back end: statistics state, sequencer for the running means and the result valid flag.
module sctm_back (
  input  logic clk,
  input  logic rst_n,
  input  logic [31:0] period_ns,
  input  logic q_valid,
  output logic q_take,
  input  sctm_pkg::evt_t q_evt,
  output logic res_valid,
  input  logic res_pop,
  output sctm_pkg::stats_t res
);
  import sctm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StStep = 3'd1;
  localparam logic [2:0] StDiv1 = 3'd2;
  localparam logic [2:0] StWait1 = 3'd3;
  localparam logic [2:0] StDiv2 = 3'd4;
  localparam logic [2:0] StWait2 = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0] st_r;
  evt_t ev_r;
  logic [31:0] cnt_r, smin_r, smax_r, smean_r, cmin_r, cmax_r, cmean_r, ovr_r;
  logic signed [31:0] lmin_r, lmax_r, lmean_r;
  logic [TsW-1:0] prev_r, dl_r, step_r;
  logic [31:0] x1_r;
  logic signed [31:0] x2_r;
  logic two_r;

  logic [TsW-1:0] diff, ldiff;
  logic [31:0] tsat;
  logic signed [31:0] lsat;
  logic div_start, div_busy;
  logic signed [33:0] div_num, div_q;
  logic [31:0] div_d;
  logic [60:0] step_prod;

  assign step_prod = {29'd0, period_ns} * {32'd0, UsRecip};

  assign diff = ev_r.ts - prev_r;
  assign tsat = (diff[TsW-1:32] != '0) ? '1 : diff[31:0];
  assign ldiff = ev_r.ts - dl_r;
  always_comb begin
    if (!ldiff[TsW-1] && ldiff[TsW-2:31] != '0) begin
      lsat = 32'sh7fffffff;
    end else if (ldiff[TsW-1] && ldiff[TsW-2:31] != '1) begin
      lsat = 32'sh80000000;
    end else begin
      lsat = $signed(ldiff[31:0]);
    end
  end

  assign div_d = cnt_r;
  always_comb begin
    if (st_r == StDiv1) begin
      div_num = (ev_r.cmd == CmdStart) ? $signed({2'b0, x1_r}) - $signed({2'b0, cmean_r})
                                       : $signed({2'b0, x1_r}) - $signed({2'b0, smean_r});
    end else begin
      div_num = 34'(x2_r) - 34'(lmean_r);
    end
  end
  assign div_start = (st_r == StDiv1) || (st_r == StDiv2);

  sctm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(div_d), .busy(div_busy), .quotient(div_q)
  );

  assign q_take = (st_r == StIdle) && q_valid && !res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      res_valid <= 1'b0;
      cnt_r <= '0; prev_r <= '0; dl_r <= '0;
      smin_r <= '1; smax_r <= '0; smean_r <= '0;
      cmin_r <= '1; cmax_r <= '0; cmean_r <= '0;
      lmin_r <= 32'sh7fffffff; lmax_r <= '0; lmean_r <= '0;
      ovr_r <= '0;
    end else begin
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (st_r)
        StIdle: begin
          if (q_take) begin
            ev_r <= q_evt;
            step_r <= TsW'(step_prod[60:UsRecipShift]);
            st_r <= StStep;
          end
        end
        StStep: begin
          st_r <= StDone;
          if (ev_r.cmd == CmdStart) begin
            if (cnt_r == '0) begin
              dl_r <= ev_r.ts + step_r;
              prev_r <= ev_r.ts;
              cnt_r <= 32'd1;
            end else begin
              x1_r <= tsat;
              x2_r <= lsat;
              two_r <= 1'b1;
              if (tsat < cmin_r) cmin_r <= tsat;
              if (tsat > cmax_r) cmax_r <= tsat;
              if (lsat < lmin_r) lmin_r <= lsat;
              if (lsat > lmax_r) lmax_r <= lsat;
              st_r <= StDiv1;
            end
          end else if (cnt_r != '0) begin
            x1_r <= tsat;
            two_r <= 1'b0;
            if (tsat < smin_r) smin_r <= tsat;
            if (tsat > smax_r) smax_r <= tsat;
            if (ev_r.ts > dl_r && ovr_r != '1) ovr_r <= ovr_r + 1'b1;
            st_r <= StDiv1;
          end
        end
        StDiv1: st_r <= StWait1;
        StWait1: begin
          if (!div_busy) begin
            if (two_r) begin
              cmean_r <= cmean_r + div_q[31:0];
              st_r <= StDiv2;
            end else begin
              smean_r <= smean_r + div_q[31:0];
              st_r <= StDone;
            end
          end
        end
        StDiv2: st_r <= StWait2;
        StWait2: begin
          if (!div_busy) begin
            lmean_r <= lmean_r + div_q[31:0];
            prev_r <= ev_r.ts;
            dl_r <= dl_r + step_r;
            if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
            st_r <= StDone;
          end
        end
        StDone: begin
          res_valid <= 1'b1;
          st_r <= StIdle;
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  always_comb begin
    res.stats_valid = (cnt_r != '0);
    res.n_start = cnt_r;
    res.st_min = smin_r;
    res.st_max = smax_r;
    res.st_mean = smean_r;
    res.ct_min = cmin_r;
    res.ct_max = cmax_r;
    res.ct_mean = cmean_r;
    res.latency_min = lmin_r;
    res.latency_max = lmax_r;
    res.latency_avg = lmean_r;
    res.overrun_count = ovr_r;
  end
endmodule

>>> sim/scan_cycle_timing_monitor_test.sv
// Self-checking testbench of the scan cycle timing monitor with a statistics predictor.
module scan_cycle_timing_monitor_test;
  import sctm_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam logic [47:0] TsMask = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic cmd;
    logic [47:0] ts;
  } event_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic in_cmd = 1'b0;
  logic [47:0] in_timestamp_us = '0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_period_ns = '0;
  logic full, empty;
  stats_t got;

  always #1 clk = ~clk;

  scan_cycle_timing_monitor u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_cmd(in_cmd), .in_timestamp_us(in_timestamp_us),
    .empty(empty), .pop(pop),
    .out_stats_valid(got.stats_valid), .out_scan_count(got.n_start),
    .out_scan_time_min(got.st_min), .out_scan_time_max(got.st_max),
    .out_scan_time_avg(got.st_mean), .out_cycle_time_min(got.ct_min),
    .out_cycle_time_max(got.ct_max), .out_cycle_time_avg(got.ct_mean),
    .out_latency_min(got.latency_min), .out_latency_max(got.latency_max),
    .out_latency_avg(got.latency_avg), .out_overrun_count(got.overrun_count),
    .cfg_we(cfg_we), .cfg_period_ns(cfg_period_ns)
  );

  // Predictor state.
  logic [31:0] period_ns;
  logic [31:0] starts;
  logic [47:0] last_start, due;
  logic [31:0] scan_lo, scan_hi, scan_avg, cyc_lo, cyc_hi, cyc_avg, ovr;
  logic signed [31:0] late_lo, late_hi, late_avg;

  event_word_t pending_words[$];
  stats_t expected_stats[$];
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned failures = 0, words_in = 0, words_out = 0, quiet = 0;
  bit hold_sender = 1'b0;

  task automatic clear_stats();
    starts = 0; last_start = 0; due = 0;
    scan_lo = '1; scan_hi = 0; scan_avg = 0;
    cyc_lo = '1; cyc_hi = 0; cyc_avg = 0;
    late_lo = 32'sh7FFF_FFFF; late_hi = 0; late_avg = 0; ovr = 0;
  endtask

  function automatic logic [31:0] clamp_u32(logic [47:0] v);
    return (v > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_s32(logic [47:0] d);
    longint s;
    s = longint'(signed'(d));
    if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic longint avg_step(longint m, longint x, logic [31:0] n);
    longint d;
    d = (n == 0) ? 1 : longint'({32'd0, n});
    return m + (x - m) / d;
  endfunction

  task automatic predict_stats(event_word_t w);
    logic [47:0] step;
    logic [31:0] ct;
    logic signed [31:0] lt;
    stats_t e;
    step = 48'(period_ns / 1000);
    if (w.cmd == CmdStart) begin
      if (starts == 0) begin
        due = (w.ts + step) & TsMask;
        last_start = w.ts;
        starts = 1;
      end else begin
        ct = clamp_u32(w.ts - last_start);
        lt = clamp_s32(w.ts - due);
        if (ct < cyc_lo) cyc_lo = ct;
        if (ct > cyc_hi) cyc_hi = ct;
        cyc_avg = 32'(avg_step(longint'({32'd0, cyc_avg}), longint'({32'd0, ct}), starts));
        if (lt < late_lo) late_lo = lt;
        if (lt > late_hi) late_hi = lt;
        late_avg = 32'(avg_step(longint'(late_avg), longint'(lt), starts));
        last_start = w.ts;
        due = due + step;
        if (starts != 32'hFFFF_FFFF) starts = starts + 1;
      end
    end else if (starts != 0) begin
      ct = clamp_u32(w.ts - last_start);
      if (ct < scan_lo) scan_lo = ct;
      if (ct > scan_hi) scan_hi = ct;
      scan_avg = 32'(avg_step(longint'({32'd0, scan_avg}), longint'({32'd0, ct}), starts));
      if (w.ts > due && ovr != 32'hFFFF_FFFF) ovr = ovr + 1;
    end
    e.stats_valid = (starts != 0);
    e.n_start = starts;
    e.st_min = scan_lo; e.st_max = scan_hi; e.st_mean = scan_avg;
    e.ct_min = cyc_lo; e.ct_max = cyc_hi; e.ct_mean = cyc_avg;
    e.latency_min = late_lo; e.latency_max = late_hi; e.latency_avg = late_avg;
    e.overrun_count = ovr;
    expected_stats.push_back(e);
  endtask

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      predict_stats(event_word_t'({in_cmd, in_timestamp_us}));
      words_in++;
    end
    if (rst_n && (push && full)) begin
      push <= 1'b1;
    end else if (rst_n && !hold_sender && pending_words.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      {in_cmd, in_timestamp_us} <= pending_words.pop_front();
    end else begin
      push <= 1'b0;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    stats_t e;
    if (rst_n && pop && !empty) begin
      words_out++;
      if (expected_stats.size() == 0) begin
        failures++;
        $display("%0t: unexpected word, actual %h", $time, got);
      end else begin
        e = expected_stats.pop_front();
        report_field("out_stats_valid", 32'(e.stats_valid), 32'(got.stats_valid));
        report_field("out_scan_count", e.n_start, got.n_start);
        report_field("out_scan_time_min", e.st_min, got.st_min);
        report_field("out_scan_time_max", e.st_max, got.st_max);
        report_field("out_scan_time_avg", e.st_mean, got.st_mean);
        report_field("out_cycle_time_min", e.ct_min, got.ct_min);
        report_field("out_cycle_time_max", e.ct_max, got.ct_max);
        report_field("out_cycle_time_avg", e.ct_mean, got.ct_mean);
        report_field("out_latency_min", e.latency_min, got.latency_min);
        report_field("out_latency_max", e.latency_max, got.latency_max);
        report_field("out_latency_avg", e.latency_avg, got.latency_avg);
        report_field("out_overrun_count", e.overrun_count, got.overrun_count);
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("[scan_cycle_timing_monitor] ERROR");
      $finish;
    end
  end

  task automatic write_period(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_period_ns <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_ns = v;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || push || expected_stats.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic event_word_t mk_word(logic c, logic [47:0] t);
    event_word_t w;
    w.cmd = c; w.ts = t;
    return w;
  endfunction

  // Regular cycles with jitter, occasional wild values.
  task automatic queue_random(int unsigned count, inout logic [47:0] now);
    logic [47:0] p;
    p = 48'(period_ns / 1000);
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: pending_words.push_back(mk_word(1'($urandom), 48'({$urandom, $urandom})));
        1: begin
          now = now + 48'({$urandom, $urandom});
          pending_words.push_back(mk_word(CmdStart, now));
        end
        default: begin
          now = now + p + 48'($urandom_range(200)) - 48'd100;
          pending_words.push_back(mk_word(CmdStart, now));
          if ($urandom_range(3) != 0)
            pending_words.push_back(mk_word(CmdEnd, now + 48'($urandom_range(
              (p > 40) ? 32'(p + p / 4) : 50))));
        end
      endcase
    end
  endtask

  initial begin
    logic [47:0] now;
    logic [31:0] periods[4];
    int unsigned idle_set[4][2];
    periods = '{32'd1000, 32'hFFFF_FFFF, 32'd999, 32'd20000000};
    idle_set = '{'{0, 0}, '{60, 0}, '{0, 60}, '{24, 24}};
    clear_stats();
    period_ns = PeriodResetNs;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: end before start, extremes, wrap, huge lateness both ways.
    pending_words.push_back(mk_word(CmdEnd, 48'd5));
    pending_words.push_back(mk_word(CmdStart, TsMask - 48'd10));
    pending_words.push_back(mk_word(CmdEnd, 48'd3));
    pending_words.push_back(mk_word(CmdStart, 48'd19990));
    pending_words.push_back(mk_word(CmdStart, 48'd39990));
    pending_words.push_back(mk_word(CmdEnd, TsMask));
    pending_words.push_back(mk_word(CmdStart, 48'h7FFF_FFFF_FFFF));
    pending_words.push_back(mk_word(CmdStart, 48'h0000_0000_0001));
    pending_words.push_back(mk_word(CmdEnd, 48'h0000_0000_0000));
    pending_words.push_back(mk_word(CmdStart, 48'hAAAA_AAAA_AAAA));
    pending_words.push_back(mk_word(CmdEnd, 48'h5555_5555_5555));
    pending_words.push_back(mk_word(CmdStart, 48'h5555_5555_5555));
    drain();
    now = 48'd1000;
    for (int ph = 0; ph < 4; ph++) begin
      write_period(periods[ph]);
      send_idle_pct = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      queue_random(120, now);
      // Hold the sender once, mid-stream, until every expected word is back.
      if (ph == 1) begin
        hold_sender = 1'b1;
        @(posedge clk);
        while (push || expected_stats.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      queue_random(120, now);
      drain();
    end
    $display("Sent %0d words and checked %0d results over four periods and idle mixes.",
             words_in, words_out);
    if (failures == 0) begin
      $display("[scan_cycle_timing_monitor] OK");
    end else begin
      $display("[scan_cycle_timing_monitor] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/sctm_pkg.sv
hdl/sctm_front.sv
hdl/sctm_div.sv
hdl/sctm_back.sv
hdl/scan_cycle_timing_monitor.sv
sim/scan_cycle_timing_monitor_test.sv
